// File: rtl/core/utc_conv_pkg.sv
// ----------------------------------------------------------------------------
// utc_conv_pkg
// Types, constants and constant tables for the Unix time / calendar converter.
// ----------------------------------------------------------------------------
package utc_conv_pkg;

	localparam int EPOCH_YEAR = 1970;
	localparam int LAST_YEAR  = 2099;
	localparam int NUM_YEARS  = LAST_YEAR - EPOCH_YEAR + 1;
	localparam int YI_W       = $clog2(NUM_YEARS + 1);
	localparam int DAYS_W     = 18;

	localparam logic OP_DATE_TO_TS = 1'b0;
	localparam logic OP_TS_TO_DATE = 1'b1;

	typedef logic [DAYS_W-1:0] days_t;
	typedef logic [YI_W-1:0]   yidx_t;
	typedef days_t ystart_tab_t [0:NUM_YEARS];
	typedef logic [8:0] mday_t;
	typedef mday_t cum_tab_t [0:13];

	function automatic logic is_leap(input int y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic ystart_tab_t build_ystart();
		ystart_tab_t t;
		int acc;
		acc = 0;
		for (int i = 0; i <= NUM_YEARS; i++) begin
			t[i] = DAYS_W'(acc);
			acc  = acc + (is_leap(EPOCH_YEAR + i) ? 366 : 365);
		end
		return t;
	endfunction

	function automatic logic [NUM_YEARS-1:0] build_leap();
		logic [NUM_YEARS-1:0] v;
		for (int i = 0; i < NUM_YEARS; i++)
			v[i] = is_leap(EPOCH_YEAR + i);
		return v;
	endfunction

	// days before month m (1-based, non-leap); entry 0 and 1 are zero, 13 is a full year
	function automatic cum_tab_t build_cum();
		cum_tab_t t;
		int len [12];
		int acc;
		len = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		acc = 0;
		t[0] = '0;
		for (int m = 1; m <= 13; m++) begin
			t[m] = 9'(acc);
			if (m <= 12)
				acc = acc + len[m-1];
		end
		return t;
	endfunction

	function automatic longint build_limit();
		ystart_tab_t t;
		longint s;
		t = build_ystart();
		s = longint'(t[NUM_YEARS]) * 86400 - 1;
		return (s > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : s;
	endfunction

	localparam ystart_tab_t          YEAR_START = build_ystart();
	localparam logic [NUM_YEARS-1:0] LEAP_TAB   = build_leap();
	localparam cum_tab_t             CUM_MONTH  = build_cum();
	localparam logic [31:0]          LIMIT      = 32'(build_limit());

	// reciprocal constants: days = (ts >> 7) * DAY_M >> 34, hour and minute likewise
	localparam logic [24:0] DAY_M  = 25'd25451658;
	localparam logic [13:0] YEAR_M = 14'd11484;
	localparam logic [15:0] HOUR_M = 16'd37283;
	localparam logic [14:0] MIN_M  = 15'd17477;

endpackage

// File: rtl/core/unix_time_calendar_convert.sv
// One conversion per request: tuser = 0 turns a date and time into seconds since
// 1970-01-01, tuser = 1 turns seconds into a date and time. The datapath is a
// twelve-stage pipeline built of constant tables and reciprocal multiplications,
// so a new request is taken every cycle unless the output stalls, and the whole
// pipeline holds while a result waits on m_tready.
// ----------------------------------------------------------------------------
// unix_time_calendar_convert
// Pipelined Unix time <-> Gregorian calendar converter with saturation.
// ----------------------------------------------------------------------------
module unix_time_calendar_convert (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// in_timestamp[31:0], in_year[43:32], in_month[47:44], in_day[52:48],
	// in_hour[57:53], in_minute[63:58], in_second[69:64], zero pad
	input  logic [71:0] s_tdata,
	// opcode
	input  logic [0:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// out_timestamp[31:0], out_year[43:32], out_month[47:44], out_day[52:48],
	// out_hour[57:53], out_minute[63:58], out_second[69:64], zero pad
	output logic [71:0] m_tdata,
	// out_of_range
	output logic [0:0]  m_tuser
);
	import utc_conv_pkg::*;

	logic        en;
	logic [12:1] v;

	assign en       = !v[12] || m_tready;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v <= '0;
		end else if (en) begin
			v <= {v[11:1], s_tvalid};
		end
	end

	// ---- stage 1: date fields to a day count and a time of day
	logic [31:0] in_ts;
	logic [11:0] in_year;
	logic [3:0]  in_month, mc;
	logic [4:0]  in_day, in_hour;
	logic [5:0]  in_minute, in_second;
	logic        yr_lo, yr_hi, yr_leap;
	yidx_t       yi_in;

	assign in_ts     = s_tdata[31:0];
	assign in_year   = s_tdata[43:32];
	assign in_month  = s_tdata[47:44];
	assign in_day    = s_tdata[52:48];
	assign in_hour   = s_tdata[57:53];
	assign in_minute = s_tdata[63:58];
	assign in_second = s_tdata[69:64];
	assign yr_lo     = in_year < 12'(EPOCH_YEAR);
	assign yr_hi     = in_year > 12'(LAST_YEAR);
	assign yi_in     = (yr_lo || yr_hi) ? '0 : YI_W'(in_year - 12'(EPOCH_YEAR));
	assign yr_leap   = LEAP_TAB[yi_in];
	assign mc        = (in_month > 4'd12) ? 4'd13 : in_month;

	logic        op_s1, lo_s1, hi_s1;
	logic [31:0] ts_s1;
	days_t       days_s1;
	logic [16:0] tod_s1;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1   <= s_tuser[0];
			ts_s1   <= in_ts;
			lo_s1   <= yr_lo;
			hi_s1   <= yr_hi;
			days_s1 <= YEAR_START[yi_in] + DAYS_W'(CUM_MONTH[mc])
				+ DAYS_W'(yr_leap && mc >= 4'd3) + DAYS_W'(in_day);
			tod_s1  <= 17'(in_hour) * 17'd3600 + 17'(in_minute) * 17'd60
				+ 17'(in_second);
		end
	end

	// ---- stage 2: scale days to seconds
	logic        op_s2, lo_s2, hi_s2;
	logic [31:0] ts_s2;
	logic [34:0] prod_s2;
	logic [16:0] tod_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			op_s2   <= op_s1;
			ts_s2   <= ts_s1;
			lo_s2   <= lo_s1;
			hi_s2   <= hi_s1;
			tod_s2  <= tod_s1;
			prod_s2 <= 35'(days_s1) * 35'd86400;
		end
	end

	// ---- stage 3: pick the timestamp, drop the day offset
	logic [34:0] total;
	assign total = prod_s2 + 35'(tod_s2);

	logic [34:0] ts_s3;
	logic        oor_s3;

	always_ff @(posedge clk) begin
		if (en) begin
			priority if (op_s2 == OP_TS_TO_DATE) begin
				ts_s3  <= 35'(ts_s2);
				oor_s3 <= 1'b0;
			end else if (lo_s2) begin
				ts_s3  <= '0;
				oor_s3 <= 1'b1;
			end else if (hi_s2) begin
				ts_s3  <= 35'(LIMIT);
				oor_s3 <= 1'b1;
			end else if (total < 35'd86400) begin
				ts_s3  <= '0;
				oor_s3 <= 1'b1;
			end else begin
				ts_s3  <= total - 35'd86400;
				oor_s3 <= 1'b0;
			end
		end
	end

	// ---- stage 4: saturate to the last supported second
	logic [31:0] ts_s4;
	logic        oor_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			if (ts_s3 > 35'(LIMIT)) begin
				ts_s4  <= LIMIT;
				oor_s4 <= 1'b1;
			end else begin
				ts_s4  <= ts_s3[31:0];
				oor_s4 <= oor_s3;
			end
		end
	end

	// ---- stages 5..8: days = ts / 86400 by reciprocal, then correct by one
	logic [31:0] ts_s5, ts_s6, ts_s7, ts_s8;
	logic        oor_s5, oor_s6, oor_s7, oor_s8;
	logic [49:0] p_s5;
	logic [15:0] q_s6, q_s7, days_s8;
	logic [32:0] qm_s7, r_full;
	logic [16:0] secs_s8;

	assign r_full = 33'(ts_s7) - qm_s7;

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s5  <= ts_s4;
			oor_s5 <= oor_s4;
			p_s5   <= 50'(ts_s4[31:7]) * 50'(DAY_M);
			ts_s6  <= ts_s5;
			oor_s6 <= oor_s5;
			q_s6   <= p_s5[49:34];
			ts_s7  <= ts_s6;
			oor_s7 <= oor_s6;
			q_s7   <= q_s6;
			qm_s7  <= 33'(q_s6) * 33'd86400;
			ts_s8  <= ts_s7;
			oor_s8 <= oor_s7;
			if (r_full >= 33'd86400) begin
				days_s8 <= q_s7 + 16'd1;
				secs_s8 <= 17'(r_full - 33'd86400);
			end else begin
				days_s8 <= q_s7;
				secs_s8 <= 17'(r_full);
			end
		end
	end

	// ---- stage 9: year estimate and hour
	logic [31:0] ts_s9;
	logic        oor_s9;
	logic [15:0] days_s9;
	logic [29:0] yp_s9;
	logic [16:0] secs_s9;
	logic [4:0]  hour_s9;
	logic [32:0] hp;

	assign hp = 33'(secs_s8) * 33'(HOUR_M);

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s9   <= ts_s8;
			oor_s9  <= oor_s8;
			days_s9 <= days_s8;
			secs_s9 <= secs_s8;
			yp_s9   <= 30'(days_s8) * 30'(YEAR_M);
			hour_s9 <= hp[31:27];
		end
	end

	// ---- stage 10: look up year starts around the estimate
	logic [7:0] est_raw;
	yidx_t      est, est_dn;
	assign est_raw = yp_s9[29:22];
	assign est     = (YI_W'(est_raw) > YI_W'(NUM_YEARS - 1)) ? YI_W'(NUM_YEARS - 1)
		: YI_W'(est_raw);
	assign est_dn  = (est == '0) ? '0 : est - YI_W'(1);

	logic [31:0] ts_s10;
	logic        oor_s10;
	logic [15:0] days_s10;
	yidx_t       est_s10;
	days_t       st0_s10, st1_s10, stm_s10;
	logic [4:0]  hour_s10;
	logic [11:0] rem_s10;

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s10   <= ts_s9;
			oor_s10  <= oor_s9;
			days_s10 <= days_s9;
			est_s10  <= est;
			st0_s10  <= YEAR_START[est];
			st1_s10  <= YEAR_START[est + YI_W'(1)];
			stm_s10  <= YEAR_START[est_dn];
			hour_s10 <= hour_s9;
			rem_s10  <= 12'(secs_s9 - 17'(hour_s9) * 17'd3600);
		end
	end

	// ---- stage 11: fix the year, minute
	days_t dd;
	assign dd = DAYS_W'(days_s10);

	logic [31:0] ts_s11;
	logic        oor_s11;
	yidx_t       yi_s11;
	logic [8:0]  remd_s11;
	logic [4:0]  hour_s11;
	logic [11:0] rem_s11;
	logic [5:0]  min_s11;
	logic [26:0] mp;

	assign mp = 27'(rem_s10) * 27'(MIN_M);

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s11   <= ts_s10;
			oor_s11  <= oor_s10;
			hour_s11 <= hour_s10;
			rem_s11  <= rem_s10;
			min_s11  <= mp[25:20];
			priority if (dd >= st1_s10 && est_s10 != YI_W'(NUM_YEARS - 1)) begin
				yi_s11   <= est_s10 + YI_W'(1);
				remd_s11 <= 9'(dd - st1_s10);
			end else if (dd < st0_s10) begin
				yi_s11   <= est_s10 - YI_W'(1);
				remd_s11 <= 9'(dd - stm_s10);
			end else begin
				yi_s11   <= est_s10;
				remd_s11 <= 9'(dd - st0_s10);
			end
		end
	end

	// ---- stage 12: month and day, second; output register
	logic       lp;
	logic [3:0] mon;
	mday_t      mbase;
	assign lp = LEAP_TAB[yi_s11];

	always_comb begin
		mon   = 4'd0;
		mbase = '0;
		for (int k = 1; k < 12; k++) begin
			if (remd_s11 >= CUM_MONTH[k+1] + mday_t'(lp && k >= 2)) begin
				mon   = 4'(k);
				mbase = CUM_MONTH[k+1] + mday_t'(lp && k >= 2);
			end
		end
	end

	logic [31:0] ts_s12;
	logic        oor_s12;
	logic [11:0] year_s12;
	logic [3:0]  mon_s12;
	logic [4:0]  day_s12, hour_s12;
	logic [5:0]  min_s12, sec_s12;

	always_ff @(posedge clk) begin
		if (en) begin
			ts_s12   <= ts_s11;
			oor_s12  <= oor_s11;
			year_s12 <= 12'(EPOCH_YEAR) + 12'(yi_s11);
			mon_s12  <= mon + 4'd1;
			day_s12  <= 5'(remd_s11 - mbase + 9'd1);
			hour_s12 <= hour_s11;
			min_s12  <= min_s11;
			sec_s12  <= 6'(rem_s11 - 12'(min_s11) * 12'd60);
		end
	end

	assign m_tvalid = v[12];
	assign m_tdata  = {2'b00, sec_s12, min_s12, hour_s12, day_s12, mon_s12, year_s12,
		ts_s12};
	assign m_tuser  = oor_s12;

`ifndef ASSERT_OFF
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow the output stall");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("stalled result changed");
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[31:0] <= LIMIT)
		else $error("timestamp beyond last supported second");
	a_time: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[57:53] < 5'd24 && m_tdata[63:58] < 6'd60
			&& m_tdata[69:64] < 6'd60)
		else $error("time of day out of range");
`endif

endmodule

// File: sim/unix_time_calendar_convert_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// unix_time_calendar_convert_tb
// Drives date and timestamp conversion requests through the converter with
// random gaps and receiver stalls, predicts each result in the bench and
// checks the results in order, whole word and range flag together.
// ----------------------------------------------------------------------------
module unix_time_calendar_convert_tb;
	import utc_conv_pkg::*;

	typedef struct packed {
		logic [1:0]  pad;
		logic [5:0]  second;
		logic [5:0]  minute;
		logic [4:0]  hour;
		logic [4:0]  day;
		logic [3:0]  month;
		logic [11:0] year;
		logic [31:0] ts;
	} cal_word_t;

	typedef struct {
		cal_word_t word;
		logic      oor;
	} cal_result_t;

	function automatic bit leap_year(longint y);
		return (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
	endfunction

	function automatic longint last_stamp();
		longint d;
		d = 0;
		for (longint y = EPOCH_YEAR; y <= LAST_YEAR; y++)
			d += leap_year(y) ? 366 : 365;
		d = d * 86400 - 1;
		return (d > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : d;
	endfunction

	function automatic cal_result_t convert(logic op, cal_word_t a);
		int mlen [12];
		cal_result_t r;
		longint lim, stamp, days, secs, tot, y, yr, mo;
		int m;
		mlen = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		lim = last_stamp();
		stamp = 0;
		r.oor = 1'b0;
		if (op == OP_TS_TO_DATE) begin
			stamp = a.ts;
		end else if (a.year < EPOCH_YEAR) begin
			r.oor = 1'b1;
		end else if (a.year > LAST_YEAR) begin
			r.oor = 1'b1;
			stamp = lim;
		end else begin
			days = 0;
			yr = a.year;
			for (y = EPOCH_YEAR; y < yr; y++)
				days += leap_year(y) ? 366 : 365;
			mo = (a.month > 12) ? 13 : a.month;
			for (m = 1; m < mo; m++) begin
				days += mlen[(m - 1) % 12];
				if (m == 2 && leap_year(yr))
					days++;
			end
			tot = (days + a.day) * 86400 + a.hour * 3600 + a.minute * 60 + a.second;
			if (tot < 86400) begin
				r.oor = 1'b1;
			end else begin
				stamp = tot - 86400;
			end
		end
		if (stamp > lim) begin
			r.oor = 1'b1;
			stamp = lim;
		end
		days = stamp / 86400;
		secs = stamp % 86400;
		yr = EPOCH_YEAR;
		while (days >= (leap_year(yr) ? 366 : 365)) begin
			days -= leap_year(yr) ? 366 : 365;
			yr++;
		end
		m = 0;
		while (m < 11) begin
			tot = mlen[m] + ((m == 1 && leap_year(yr)) ? 1 : 0);
			if (days < tot)
				break;
			days -= tot;
			m++;
		end
		r.word = '0;
		r.word.ts = stamp[31:0];
		r.word.year = yr[11:0];
		r.word.month = 4'(m + 1);
		r.word.day = 5'(days + 1);
		r.word.hour = 5'(secs / 3600);
		r.word.minute = 6'((secs % 3600) / 60);
		r.word.second = 6'(secs % 60);
		return r;
	endfunction

	class conv_scoreboard;
		cal_result_t pending [$];
		int errors = 0;

		function void note_request(logic op, cal_word_t a);
			pending.push_back(convert(op, a));
		endfunction

		function void check_result(cal_word_t w, logic oor);
			cal_result_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result %h oor %b", w, oor);
				return;
			end
			e = pending.pop_front();
			if (w !== e.word || oor !== e.oor) begin
				errors++;
				if (errors <= 10)
					$display("mismatch: expected %h oor %b, got %h oor %b",
						e.word, e.oor, w, oor);
			end
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        s_tvalid;
	logic        s_tready;
	logic [71:0] s_tdata;
	logic [0:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [71:0] m_tdata;
	logic [0:0]  m_tuser;

	conv_scoreboard board;
	bit   hold_off;
	longint cycles;

	unix_time_calendar_convert i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// drop valid only when a gap follows, so back-to-back requests keep it high
	task automatic send_request(logic op, cal_word_t a);
		int gap;
		gap = $urandom_range(0, 7);
		if ($urandom_range(0, 3) == 0)
			gap = 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= a;
		s_tuser  <= op;
		do @(posedge clk); while (!s_tready);
		board.note_request(op, a);
	endtask

	function automatic cal_word_t make_date(int y, int mo, int d, int h, int mi, int s);
		cal_word_t a;
		a = '0;
		a.ts = $urandom;
		a.year = 12'(y);
		a.month = 4'(mo);
		a.day = 5'(d);
		a.hour = 5'(h);
		a.minute = 6'(mi);
		a.second = 6'(s);
		return a;
	endfunction

	function automatic cal_word_t make_stamp(logic [31:0] t);
		cal_word_t a;
		a = make_date($urandom_range(0, 4095), $urandom_range(0, 15),
			$urandom_range(0, 31), $urandom_range(0, 31),
			$urandom_range(0, 63), $urandom_range(0, 63));
		a.ts = t;
		return a;
	endfunction

	// receiver: random stalls, one long hold-off partway through
	initial begin
		int wait_n;
		wait_n = 0;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_off) begin
				m_tready <= 1'b0;
			end else if (m_tready && m_tvalid) begin
				wait_n = $urandom_range(0, 7);
				if ($urandom_range(0, 3) == 0)
					wait_n = 0;
				m_tready <= (wait_n == 0);
			end else if (!m_tready) begin
				if (wait_n > 0)
					wait_n--;
				m_tready <= (wait_n == 0);
			end
		end
	end

	initial begin
		hold_off = 1'b0;
		@(posedge arst_n);
		repeat (3000) @(posedge clk);
		hold_off = 1'b1;
		repeat (300) @(posedge clk);
		hold_off = 1'b0;
	end

	always @(posedge clk)
		if (arst_n && m_tvalid && m_tready)
			board.check_result(m_tdata, m_tuser[0]);

	initial begin
		cycles = 0;
		forever begin
			@(posedge clk);
			cycles++;
			if (cycles > 400000) begin
				$display("unix_time_calendar_convert verification failed");
				$finish;
			end
		end
	end

	initial begin
		cal_word_t a;
		int k, y;
		board = new();
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: epoch, leap days, limits, spill-over and out of range
		send_request(OP_DATE_TO_TS, make_date(1970, 1, 1, 0, 0, 0));
		send_request(OP_DATE_TO_TS, make_date(2099, 12, 31, 23, 59, 59));
		send_request(OP_DATE_TO_TS, make_date(2000, 2, 29, 12, 30, 30));
		send_request(OP_DATE_TO_TS, make_date(2100, 1, 1, 0, 0, 0));
		send_request(OP_DATE_TO_TS, make_date(1969, 12, 31, 0, 0, 0));
		send_request(OP_DATE_TO_TS, make_date(4095, 15, 31, 31, 63, 63));
		send_request(OP_DATE_TO_TS, make_date(0, 0, 0, 0, 0, 0));
		send_request(OP_DATE_TO_TS, make_date(1970, 1, 0, 23, 59, 59));
		send_request(OP_DATE_TO_TS, make_date(1970, 0, 0, 31, 63, 63));
		send_request(OP_DATE_TO_TS, make_date(2023, 2, 31, 0, 0, 0));
		send_request(OP_DATE_TO_TS, make_date(2099, 15, 31, 31, 63, 63));
		send_request(OP_DATE_TO_TS, make_date(2038, 1, 19, 3, 14, 8));
		send_request(OP_DATE_TO_TS, make_date(1972, 13, 0, 0, 0, 0));
		send_request(OP_TS_TO_DATE, make_stamp(32'd0));
		send_request(OP_TS_TO_DATE, make_stamp(32'hFFFF_FFFF));
		send_request(OP_TS_TO_DATE, make_stamp(LIMIT));
		send_request(OP_TS_TO_DATE, make_stamp(LIMIT + 1));
		send_request(OP_TS_TO_DATE, make_stamp(32'd951782400));
		send_request(OP_TS_TO_DATE, make_stamp(32'd86399));
		send_request(OP_TS_TO_DATE, make_stamp(32'h7FFF_FFFF));

		for (k = 0; k < 1500; k++) begin
			case ($urandom_range(0, 9))
				0, 1, 2, 3: send_request(OP_DATE_TO_TS, make_date(
					$urandom_range(1970, 2099), $urandom_range(1, 12),
					$urandom_range(1, 31), $urandom_range(0, 23),
					$urandom_range(0, 59), $urandom_range(0, 59)));
				4: begin
					// year boundaries, leap and century years
					y = $urandom_range(0, 1) ? $urandom_range(1970, 2099) : 2000;
					send_request(OP_DATE_TO_TS, make_date(y, $urandom_range(0, 1) ? 12 : 1,
						$urandom_range(0, 1) ? 31 : 0, $urandom_range(0, 31),
						$urandom_range(0, 63), $urandom_range(0, 63)));
				end
				5: send_request(OP_DATE_TO_TS, make_date(
					$urandom_range(0, 4095), $urandom_range(0, 15),
					$urandom_range(0, 31), $urandom_range(0, 31),
					$urandom_range(0, 63), $urandom_range(0, 63)));
				6, 7: send_request(OP_TS_TO_DATE, make_stamp($urandom_range(0, LIMIT)));
				8: send_request(OP_TS_TO_DATE, make_stamp($urandom));
				default: send_request(OP_TS_TO_DATE,
					make_stamp(LIMIT - 32'($urandom_range(0, 200000)) +
						32'($urandom_range(0, 100000))));
			endcase
		end
		s_tvalid <= 1'b0;

		while (board.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		if (board.errors == 0)
			$display("unix_time_calendar_convert verification clean");
		else
			$display("unix_time_calendar_convert verification failed");
		$finish;
	end

endmodule
